// ----- rtl/bdi_pkg.sv -----
// ----------------------------------------------------------------------------
// bdi_pkg
// Shared constants, types and codes for the base-delta-immediate block
// compressor: block geometry, result kinds, tag values and control bundles.
// ----------------------------------------------------------------------------
package bdi_pkg;

  // Block geometry
  localparam int unsigned BLOCK_WORDS = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned IDX_W       = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int unsigned CNT_W       = $clog2(BLOCK_WORDS + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TAG   = 2'd0,
    KIND_BASE  = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_RAW   = 2'd3
  } kind_e;

  // Tag values
  localparam logic TAG_RAW    = 1'b0;
  localparam logic TAG_PACKED = 1'b1;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_FILL = 4'b0001,
    ST_TAG  = 4'b0010,
    ST_BASE = 4'b0100,
    ST_BODY = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic  wr_en;     // store the incoming word
    idx_t  wr_idx;    // slot for the incoming word
    logic  first;     // incoming word opens a block (becomes base)
    logic  load;      // load the output register
    kind_e kind;      // kind of the item to load
    idx_t  rd_idx;    // stored word to show
    logic  tag;       // tag value for a tag item
    logic  last;      // item closes the block
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fit_next;   // block still packs once the incoming word is in
  } status_t;

endpackage

// ----- rtl/bdi_if.sv -----
// ----------------------------------------------------------------------------
// bdi_if
// Valid/ready stream interfaces of the compressor: word input and result
// output.
// ----------------------------------------------------------------------------
interface bdi_in_if;
  logic          valid;
  logic          ready;
  bdi_pkg::word_t word;
  logic          last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

interface bdi_out_if;
  logic           valid;
  logic           ready;
  logic [1:0]     kind;
  bdi_pkg::word_t value;
  logic           last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ----- rtl/bdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdi_ctrl
// Controller: counts words into the block, decides packed or raw, and steps
// through the result items while holding the output register's valid.
// ----------------------------------------------------------------------------
module bdi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_word_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bdi_pkg::status_t status_i,
  output bdi_pkg::cmd_t    cmd_o
);

  bdi_pkg::state_e state_q, state_d;
  bdi_pkg::cnt_t   fill_q, fill_d;
  bdi_pkg::idx_t   idx_q, idx_d;
  logic            packed_q, packed_d;
  logic            out_valid_q, out_valid_d;

  logic            in_beat;
  logic            load_ok;
  logic            body_last;
  bdi_pkg::cnt_t   fill_inc;

  assign in_ready_o  = (state_q == bdi_pkg::ST_FILL);
  assign in_beat     = in_valid_i && in_ready_o;
  assign load_ok     = !out_valid_q || out_ready_i;
  assign fill_inc    = fill_q + bdi_pkg::cnt_t'(1);
  assign body_last   = ((bdi_pkg::cnt_t'(idx_q) + bdi_pkg::cnt_t'(1)) == fill_q);
  assign out_valid_o = out_valid_q;

  // Sequence the block: fill, then tag, optional base, then body items
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    packed_d = packed_q;

    cmd_o        = '0;
    cmd_o.wr_idx = fill_q[bdi_pkg::IDX_W-1:0];
    cmd_o.first  = (fill_q == '0);
    cmd_o.rd_idx = idx_q;
    cmd_o.tag    = packed_q ? bdi_pkg::TAG_PACKED : bdi_pkg::TAG_RAW;
    cmd_o.kind   = bdi_pkg::KIND_TAG;

    unique case (state_q)
      bdi_pkg::ST_FILL: begin
        if (in_beat) begin
          cmd_o.wr_en = 1'b1;
          fill_d      = fill_inc;
          if (fill_inc == bdi_pkg::cnt_t'(bdi_pkg::BLOCK_WORDS) || in_last_word_i) begin
            packed_d = (fill_inc == bdi_pkg::cnt_t'(bdi_pkg::BLOCK_WORDS)) &&
                       status_i.fit_next;
            state_d  = bdi_pkg::ST_TAG;
          end
        end
      end
      bdi_pkg::ST_TAG: begin
        cmd_o.kind = bdi_pkg::KIND_TAG;
        if (load_ok) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = packed_q ? bdi_pkg::ST_BASE : bdi_pkg::ST_BODY;
        end
      end
      bdi_pkg::ST_BASE: begin
        cmd_o.kind = bdi_pkg::KIND_BASE;
        if (load_ok) begin
          cmd_o.load = 1'b1;
          state_d    = bdi_pkg::ST_BODY;
        end
      end
      bdi_pkg::ST_BODY: begin
        cmd_o.kind = packed_q ? bdi_pkg::KIND_DELTA : bdi_pkg::KIND_RAW;
        cmd_o.last = body_last;
        if (load_ok) begin
          cmd_o.load = 1'b1;
          if (body_last) begin
            fill_d  = '0;
            state_d = bdi_pkg::ST_FILL;
          end else begin
            idx_d = idx_q + bdi_pkg::idx_t'(1);
          end
        end
      end
      default: begin
        state_d = bdi_pkg::ST_FILL;
      end
    endcase
  end

  // Hold the output item until the sink takes it
  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdi_pkg::ST_FILL;
      fill_q      <= '0;
      idx_q       <= '0;
      packed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      packed_q    <= packed_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/bdi_dp.sv -----
// ----------------------------------------------------------------------------
// bdi_dp
// Datapath: block word store, base register, running range check and the
// output payload register.
// ----------------------------------------------------------------------------
module bdi_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdi_pkg::word_t   word_i,
  input  bdi_pkg::cmd_t    cmd_i,
  output bdi_pkg::status_t status_o,
  output logic [1:0]       kind_o,
  output bdi_pkg::word_t   value_o,
  output logic             last_o
);

  bdi_pkg::word_t store_q [bdi_pkg::BLOCK_WORDS];
  bdi_pkg::word_t base_q;
  logic           fit_q;

  bdi_pkg::word_t diff;
  logic           word_fits;
  bdi_pkg::word_t rd_word;
  logic [bdi_pkg::DELTA_W-1:0] delta;

  bdi_pkg::word_t value_d;
  logic [1:0]     kind_q;
  bdi_pkg::word_t value_q;
  logic           last_q;

  // Range check: difference sign-extends from bit 15
  assign diff      = word_i - base_q;
  assign word_fits = (&diff[bdi_pkg::WORD_W-1:bdi_pkg::DELTA_W-1]) ||
                     !(|diff[bdi_pkg::WORD_W-1:bdi_pkg::DELTA_W-1]);
  assign status_o.fit_next = cmd_i.first ? 1'b1 : (fit_q && word_fits);

  // Store the word; the first word of a block becomes the base
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[cmd_i.wr_idx] <= word_i;
      if (cmd_i.first) begin
        base_q <= word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= 1'b1;
    end else if (cmd_i.wr_en) begin
      fit_q <= status_o.fit_next;
    end
  end

  // Select the payload of the next result item
  assign rd_word = store_q[cmd_i.rd_idx];
  assign delta   = rd_word[bdi_pkg::DELTA_W-1:0] - base_q[bdi_pkg::DELTA_W-1:0];

  always_comb begin
    case (cmd_i.kind)
      bdi_pkg::KIND_TAG:   value_d = {{(bdi_pkg::WORD_W-1){1'b0}}, cmd_i.tag};
      bdi_pkg::KIND_BASE:  value_d = base_q;
      bdi_pkg::KIND_DELTA: value_d = {{(bdi_pkg::WORD_W-bdi_pkg::DELTA_W){1'b0}}, delta};
      default:             value_d = rd_word;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= cmd_i.kind;
      value_q <= value_d;
      last_q  <= cmd_i.last;
    end
  end

  assign kind_o  = kind_q;
  assign value_o = value_q;
  assign last_o  = last_q;

endmodule

// ----- rtl/bdi_block_compressor.sv -----
// ----------------------------------------------------------------------------
// bdi_block_compressor
// Base-delta-immediate block compressor: gathers 64-bit words into blocks and
// emits each block as packed base plus 16-bit deltas, or as raw words.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | beat when
//  in_i    | in  | word[63:0], last_word        | valid && ready
//  out_o   | out | kind[1:0], value[63:0], last | valid && ready
//
//  Words are taken on every valid beat; ready drops once a block is complete.
//  A complete block then emits one result per cycle while the sink is ready,
//  from the output register: tag, base (packed only) and one item per word,
//  set by the emit sequencer. A packed block of eight words emits ten items.
//  Reset clears the controller; the word store needs no clearing.
//  A stalled output sink holds the sequencer on the current item.
// ----------------------------------------------------------------------------
module bdi_block_compressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdi_in_if.sink     in_i,
  bdi_out_if.source  out_o
);

  bdi_pkg::cmd_t    cmd;
  bdi_pkg::status_t status;

  bdi_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_last_word_i (in_i.last_word),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  bdi_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (in_i.word),
    .cmd_i    (cmd),
    .status_o (status),
    .kind_o   (out_o.kind),
    .value_o  (out_o.value),
    .last_o   (out_o.last)
  );

endmodule

// ----- rtl/bdi_checker.sv -----
// ----------------------------------------------------------------------------
// bdi_checker
// Port-level checks of the compressor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bdi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_last_word_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic [1:0]     out_kind_i,
  input bdi_pkg::word_t out_value_i,
  input logic           out_last_i
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_kind_i) && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // No input is taken while a block is still being emitted
  a_no_in_mid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a block");

  // Final word of a stream closes the block
  a_flush_stops_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_word_i |=> !in_ready_i)
    else $error("input still ready after stream end");

  // Tag item carries only 0 or 1 and never ends a block
  a_tag_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == bdi_pkg::KIND_TAG) |->
      (out_value_i[bdi_pkg::WORD_W-1:1] == '0) && !out_last_i)
    else $error("malformed tag item");

  // Delta item has its upper bits clear
  a_delta_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == bdi_pkg::KIND_DELTA) |->
      (out_value_i[bdi_pkg::WORD_W-1:bdi_pkg::DELTA_W] == '0))
    else $error("delta item wider than 16 bits");

endmodule

bind bdi_block_compressor bdi_checker u_bdi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_word_i (in_i.last_word),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_value_i    (out_o.value),
  .out_last_i     (out_o.last)
);

// ----- tb/bdi_block_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdi_block_checker
// Watches the word and result channels of the block compressor. Every
// accepted input word feeds a block predictor that queues the tag, base,
// delta and raw items the block should emit; every accepted result beat is
// compared with the oldest queued item.
// ----------------------------------------------------------------------------
module bdi_block_checker
  import bdi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bdi_in_if           word_i,
  bdi_out_if          result_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    kind_e kind;
    word_t value;
    logic  last;
  } result_t;

  result_t     expected_q[$];
  result_t     oldest;
  word_t       blk_words[BLOCK_WORDS];
  int unsigned fill;
  logic        packs;
  int unsigned fails;

  // True when w - base, read as signed, lies within the 16-bit delta range
  function automatic logic delta_in_range(word_t w, word_t base);
    word_t d;
    d = w - base;
    return (d + 64'd32768) < 64'd65536;
  endfunction

  // Append one expected item at the tail of the queue
  function automatic void queue_result(kind_e k, word_t v, logic l);
    expected_q.insert(expected_q.size(), result_t'{kind: k, value: v, last: l});
  endfunction

  // Add one word to the current block; queue the block once it closes
  function automatic void compress_word(word_t w, logic lw);
    word_t base;
    word_t diff;
    blk_words[fill] = w;
    if (fill != 0 && !delta_in_range(w, blk_words[0])) packs = 1'b0;
    fill++;
    if (fill < BLOCK_WORDS && !lw) return;

    base = blk_words[0];
    if (fill == BLOCK_WORDS && packs) begin
      queue_result(KIND_TAG, word_t'(TAG_PACKED), 1'b0);
      queue_result(KIND_BASE, base, 1'b0);
      for (int j = 0; j < BLOCK_WORDS; j++) begin
        diff = blk_words[j] - base;
        queue_result(KIND_DELTA, word_t'(diff[DELTA_W-1:0]), j == BLOCK_WORDS - 1);
      end
    end else begin
      // partial blocks and blocks with an outlier go out raw
      queue_result(KIND_TAG, word_t'(TAG_RAW), 1'b0);
      for (int j = 0; j < fill; j++) begin
        queue_result(KIND_RAW, blk_words[j], j == fill - 1);
      end
    end
    fill  = 0;
    packs = 1'b1;
  endfunction

  // Predict on word beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      fill       = 0;
      packs      = 1'b1;
      fails      = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (word_i.valid && word_i.ready) begin
        compress_word(word_i.word, word_i.last_word);
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat kind %0d value %h last %b",
                   $time, result_i.kind, result_i.value, result_i.last);
        end else begin
          oldest = expected_q.pop_front();
          if (result_i.kind !== oldest.kind || result_i.value !== oldest.value ||
              result_i.last !== oldest.last) begin
            fails++;
            $display({"%0t: result mismatch: expected kind %0d value %h last %b,",
                      " got kind %0d value %h last %b"},
                     $time, oldest.kind, oldest.value, oldest.last,
                     result_i.kind, result_i.value, result_i.last);
          end
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= expected_q.size();
    end
  end

endmodule

// ----- tb/tb_bdi_block_compressor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bdi_block_compressor
// Drives 64-bit words into the block compressor and drains its results with
// random gaps and stalls on both channels. A directed set covers wrapping
// deltas, range edges, partial and single-word flushes; random blocks of
// fitting, borderline and scattered words follow. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bdi_block_compressor;
  import bdi_pkg::*;

  localparam int unsigned STALL_MAX    = 13;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS = 100;
  localparam int unsigned SETTLE_CYC   = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  bdi_in_if  word_ch ();
  bdi_out_if res_ch ();

  bdi_block_compressor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_ch),
    .out_o  (res_ch)
  );

  bdi_block_checker checker_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_i     (word_ch),
    .result_i   (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  function automatic word_t offset_word(word_t base, int off);
    return base + word_t'(longint'(off));
  endfunction

  // Result sink: hold ready low for a random gap, possibly none, before each beat
  initial begin : result_sink
    bit          calm;
    int unsigned gap;
    int unsigned beats;
    res_ch.ready = 1'b0;
    calm  = 1'b0;
    beats = 0;
    forever begin
      if (beats % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = draw_gap(calm);
      if (gap > 0) begin
        @(negedge clk_i) res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      beats++;
    end
  end

  bit          send_calm = 1'b0;
  int unsigned words_sent = 0;

  // Drive one word; return right after the beat with valid still high
  task automatic send_word(input word_t w, input logic lw);
    int unsigned gap;
    if (words_sent % 16 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk_i) word_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    word_ch.valid     <= 1'b1;
    word_ch.word      <= w;
    word_ch.last_word <= lw;
    @(posedge clk_i);
    while (!word_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Hold the sender until every queued result has come out
  task automatic drain_results();
    @(negedge clk_i) word_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_directed();
    word_t base;
    // full block that packs, deltas wrapping past the top end of 2^64,
    // closed by a word that also carries the stream end
    base = 64'hFFFF_FFFF_FFFF_FFF0;
    send_word(base, 1'b0);
    send_word(offset_word(base, 32767), 1'b0);
    send_word(offset_word(base, -32768), 1'b0);
    send_word(offset_word(base, 16), 1'b0);
    send_word(offset_word(base, -1), 1'b0);
    send_word(offset_word(base, 15), 1'b0);
    send_word(offset_word(base, 1), 1'b0);
    send_word(offset_word(base, 5), 1'b1);
    // full block with deltas just outside the range: raw
    base = 64'h0;
    send_word(base, 1'b0);
    send_word(offset_word(base, 32768), 1'b0);
    send_word(offset_word(base, -32769), 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    // partial block whose deltas fit still goes out raw
    base = 64'h1234_5678_9ABC_DEF0;
    send_word(base, 1'b0);
    send_word(offset_word(base, 100), 1'b0);
    send_word(offset_word(base, -100), 1'b1);
    // single-word block
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  function automatic word_t pick_base();
    word_t b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: b = word_t'($urandom_range(0, 40000));
      1: b = ~word_t'($urandom_range(0, 40000));
      2: b = 64'h8000_0000_0000_0000 + word_t'($urandom_range(0, 40000));
      3: b = 64'h7FFF_FFFF_FFFF_FFFF - word_t'($urandom_range(0, 40000));
      default: ;
    endcase
    return b;
  endfunction

  function automatic int edge_offset();
    case ($urandom_range(0, 6))
      0: return -32769;
      1: return -32768;
      2: return 32767;
      3: return 32768;
      4: return -1;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  // Random blocks: mostly fitting deltas, some borderline, some scattered
  task automatic send_random();
    word_t       base;
    word_t       w;
    logic        lw;
    int unsigned pos;
    int unsigned flavor;
    int unsigned sent;
    pos    = 0;
    flavor = 0;
    base   = '0;
    for (sent = 0; sent < RANDOM_WORDS; sent++) begin
      if (pos == 0) begin
        flavor = $urandom_range(0, 9);
        base   = pick_base();
        w      = base;
      end else if (flavor <= 5) begin
        w = offset_word(base, int'($urandom_range(0, 65535)) - 32768);
      end else if (flavor <= 7) begin
        w = ($urandom_range(0, 2) == 0) ?
            offset_word(base, edge_offset()) :
            offset_word(base, int'($urandom_range(0, 65535)) - 32768);
      end else begin
        w = {$urandom, $urandom};
      end
      lw = ($urandom_range(0, 11) == 0) || (sent == RANDOM_WORDS - 1);
      send_word(w, lw);
      pos = (lw || pos == BLOCK_WORDS - 1) ? 0 : pos + 1;
      if (sent == RANDOM_WORDS / 2) drain_results();
    end
  endtask

  initial begin : stimulus
    int unsigned waited;
    word_ch.valid     = 1'b0;
    word_ch.word      = '0;
    word_ch.last_word = 1'b0;
    rst_ni            = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_directed();
    drain_results();
    send_random();

    // let the last block drain, then settle
    drain_results();
    for (waited = 0; waited < SETTLE_CYC; waited++) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- bdi_block_compressor.f -----
rtl/bdi_pkg.sv
rtl/bdi_if.sv
rtl/bdi_ctrl.sv
rtl/bdi_dp.sv
rtl/bdi_block_compressor.sv
rtl/bdi_checker.sv
tb/bdi_block_checker.sv
tb/tb_bdi_block_compressor.sv
